// ----- hw/rtl/ptse_pkg.sv -----
// Shared types and constants of the price trend signal engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ptse_pkg;

  localparam int PRICE_W    = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;
  localparam int TREND_LEN  = 3;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [MODE_W-1:0]         mode_t;

  localparam cfg_idx_t REG_STRATEGY_MODE = 1'd0;
  localparam cfg_idx_t REG_WINDOW_LENGTH = 1'd1;

  localparam mode_t MODE_TREND    = 2'd0;
  localparam mode_t MODE_AVERAGE  = 2'd1;
  localparam mode_t MODE_BREAKOUT = 2'd2;

  localparam mode_t     MODE_RESET = MODE_TREND;
  localparam cfg_data_t WLEN_RESET = 5'd3;

  localparam price_t PRICE_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
  localparam price_t PRICE_MAX = {1'b0, {(PRICE_W-1){1'b1}}};

endpackage

`default_nettype wire

// ----- hw/rtl/ptse_if.sv -----
// Handshake interfaces of the price trend signal engine: price input,
// buy/sell output and configuration writes. Depends on ptse_pkg.
`default_nettype none

interface ptse_price_if;
  import ptse_pkg::*;
  logic   valid;
  logic   ready;
  price_t price;
  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface ptse_flag_if;
  logic valid;
  logic ready;
  logic buy;
  logic sell;
  modport source (output valid, output buy, output sell, input ready);
  modport sink (input valid, input buy, input sell, output ready);
endinterface

interface ptse_cfg_if;
  import ptse_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ptse_cell.sv -----
// One history cell: holds one previous price and, inside the window, folds it
// into the sum/max/min transaction token passing by. Depends on ptse_pkg.
`default_nettype none

module ptse_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 5,
  parameter int SUM_W = 38
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    shift,
  input  wire ptse_pkg::price_t        price_in,
  output ptse_pkg::price_t             price,
  input  wire logic [LEN_W-1:0]        len,
  input  wire logic                    tok_valid_in,
  input  wire logic signed [SUM_W-1:0] tok_sum_in,
  input  wire ptse_pkg::price_t        tok_max_in,
  input  wire ptse_pkg::price_t        tok_min_in,
  output logic                         tok_valid_out,
  output logic signed [SUM_W-1:0]      tok_sum_out,
  output ptse_pkg::price_t             tok_max_out,
  output ptse_pkg::price_t             tok_min_out
);
  import ptse_pkg::*;

  logic in_window;

  assign in_window = LEN_W'(IDX) < len;

  always_ff @(posedge clk) begin
    if (shift) begin
      price <= price_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_window) begin
      tok_sum_out <= tok_sum_in + SUM_W'(price);
      tok_max_out <= (price > tok_max_in) ? price : tok_max_in;
      tok_min_out <= (price < tok_min_in) ? price : tok_min_in;
    end else begin
      tok_sum_out <= tok_sum_in;
      tok_max_out <= tok_max_in;
      tok_min_out <= tok_min_in;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/price_trend_signal_engine.sv -----
// Top level of the price trend signal engine: configuration registers,
// sequencer, output register and the chain of ptse_cell history cells.
// Depends on ptse_pkg, the interfaces in ptse_if.sv and ptse_cell.
// Each accepted price sends one token down a chain of WINDOW_MAX cells.
// No new price is accepted until the token has left the chain and the result is
// in the output register. Synchronous reset clears the sample count and all
// valids and sets the configuration registers to their reset values.
`default_nettype none

module price_trend_signal_engine #(
  parameter int WINDOW_MAX = 16
) (
  input wire logic clk,
  input wire logic rst,
  ptse_price_if.sink   prices,
  ptse_flag_if.source  flags,
  ptse_cfg_if.sink     cfg
);
  import ptse_pkg::*;

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SEEN_W = $clog2(WINDOW_MAX + 2);
  localparam int SUM_W  = PRICE_W + LEN_W + 1;
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WINDOW_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  mode_t             mode;
  cfg_data_t         wlen;
  logic [LEN_W-1:0]  len;
  logic [SEEN_W-1:0] seen;
  logic [SEEN_W-1:0] seen_inc;
  logic              gate;
  logic              gate_now;
  price_t            p;
  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] sum_f;
  price_t            max_f;
  price_t            min_f;
  logic              in_acc;
  logic              out_free;
  logic              finish;
  logic              buy_next;
  logic              sell_next;

  logic [WINDOW_MAX:0]     tok_valid;
  logic signed [SUM_W-1:0] tok_sum [WINDOW_MAX+1];
  price_t                  tok_max [WINDOW_MAX+1];
  price_t                  tok_min [WINDOW_MAX+1];
  price_t                  hist    [WINDOW_MAX];

  assign cfg.ready    = 1'b1;
  assign prices.ready = (state == S_IDLE);
  assign in_acc       = prices.valid && prices.ready;
  assign out_free     = !flags.valid || flags.ready;
  assign finish       = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
      wlen <= WLEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STRATEGY_MODE: mode <= cfg.data[MODE_W-1:0];
        REG_WINDOW_LENGTH: wlen <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (wlen == '0) begin
      len = LEN_W'(1);
    end else if (32'(wlen) > 32'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(wlen);
    end
  end

  assign seen_inc = (seen == SEEN_MAX) ? seen : seen + SEEN_W'(1);

  always_comb begin
    if (mode == MODE_TREND) begin
      gate_now = 32'(seen_inc) >= 32'(TREND_LEN);
    end else begin
      gate_now = 32'(seen_inc) > 32'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_acc) begin
      seen <= seen_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p    <= prices.price;
      gate <= gate_now;
    end
    scaled <= SUM_W'(p) * SUM_W'($signed({1'b0, len}));
    if (tok_valid[WINDOW_MAX]) begin
      sum_f <= tok_sum[WINDOW_MAX];
      max_f <= tok_max[WINDOW_MAX];
      min_f <= tok_min[WINDOW_MAX];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_RUN;
      S_RUN:  if (tok_valid[WINDOW_MAX]) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign tok_valid[0] = in_acc;
  assign tok_sum[0]   = '0;
  assign tok_max[0]   = PRICE_MIN;
  assign tok_min[0]   = PRICE_MAX;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    price_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = p;
    end else begin : g_body
      assign cell_in = hist[i-1];
    end
    ptse_cell #(
      .IDX   (i),
      .LEN_W (LEN_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .shift         (finish),
      .price_in      (cell_in),
      .price         (hist[i]),
      .len           (len),
      .tok_valid_in  (tok_valid[i]),
      .tok_sum_in    (tok_sum[i]),
      .tok_max_in    (tok_max[i]),
      .tok_min_in    (tok_min[i]),
      .tok_valid_out (tok_valid[i+1]),
      .tok_sum_out   (tok_sum[i+1]),
      .tok_max_out   (tok_max[i+1]),
      .tok_min_out   (tok_min[i+1])
    );
  end

  always_comb begin
    buy_next  = 1'b0;
    sell_next = 1'b0;
    unique case (mode)
      MODE_TREND: begin
        buy_next  = gate && (hist[1] < hist[0]) && (hist[0] < p);
        sell_next = gate && (hist[1] > hist[0]) && (hist[0] > p);
      end
      MODE_AVERAGE: begin
        buy_next  = gate && (scaled > sum_f);
        sell_next = gate && (scaled < sum_f);
      end
      MODE_BREAKOUT: begin
        buy_next  = gate && (p > max_f);
        sell_next = gate && (p < min_f);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (finish) begin
      flags.valid <= 1'b1;
    end else if (flags.ready) begin
      flags.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      flags.buy  <= buy_next;
      flags.sell <= sell_next;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("More than one transaction token in the cell chain.");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tok_valid[WINDOW_MAX] |-> state == S_RUN)
    else $error("Token left the chain outside the run state.");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    finish |=> flags.valid && state == S_IDLE)
    else $error("Finished transaction did not reach the output register.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    flags.valid |-> !(flags.buy && flags.sell))
    else $error("Buy and sell raised together.");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen <= SEEN_MAX)
    else $error("Sample count passed its saturation value.");

endmodule

`default_nettype wire
